### rtl/core/spt_pkg.sv
package spt_pkg;

	// Table geometry
	localparam int SLOTS       = 16;
	localparam int DEGREE_BITS = 8;

	localparam int COEF_W  = 32;
	localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PROD_W  = COEF_W + DEGREE_BITS + 1;
	localparam int DEG_EXT = (DEGREE_BITS > 8) ? DEGREE_BITS : 8;
	localparam int PTR_EXT = (IDX_W > 4) ? IDX_W : 4;

	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);
	localparam logic [31:0]      SLOTS_W32 = 32'(SLOTS);

	localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	typedef logic [DEGREE_BITS-1:0] deg_t;
	typedef logic [IDX_W-1:0]       ptr_t;

	// Command codes
	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_DIFF  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_code_t;

	// Status codes
	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_SAT  = 2'd2
	} stat_code_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_SCAN,
		S_ADD_SEL,
		S_ADD_APPLY,
		S_DIFF_MUL,
		S_DIFF_WR,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]               command;
		logic signed [COEF_W-1:0] coef_value;
		logic [7:0]               degree;
		logic [3:0]               slot_index;
	} spt_req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [COEF_W-1:0] read_coef;
		logic [7:0]               read_degree;
		logic                     read_live;
	} spt_rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic scan;
		logic ptr_sel;
		logic apply;
		logic mul;
		logic diff_wr;
		logic finish;
	} spt_ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic ptr_last;
	} spt_sts_t;

	typedef struct packed {
		logic                     sat;
		logic signed [COEF_W-1:0] val;
	} coef_sat_t;

	// Saturating sum of two coefficients
	function automatic coef_sat_t sat_add(logic signed [COEF_W-1:0] a,
			logic signed [COEF_W-1:0] b);
		logic signed [COEF_W:0] s;
		coef_sat_t r;
		s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
		r.sat = s[COEF_W] ^ s[COEF_W-1];
		if (r.sat) begin
			r.val = s[COEF_W] ? COEF_MIN : COEF_MAX;
		end else begin
			r.val = s[COEF_W-1:0];
		end
		return r;
	endfunction

	// Clamp a coefficient-by-degree product to the coefficient range
	function automatic coef_sat_t clamp_prod(logic signed [PROD_W-1:0] p);
		coef_sat_t r;
		r.sat = !((&p[PROD_W-1:COEF_W-1]) || !(|p[PROD_W-1:COEF_W-1]));
		if (r.sat) begin
			r.val = p[PROD_W-1] ? COEF_MIN : COEF_MAX;
		end else begin
			r.val = p[COEF_W-1:0];
		end
		return r;
	endfunction

	// Keep the low DEGREE_BITS of an input degree
	function automatic deg_t to_deg(logic [7:0] d);
		logic [DEG_EXT-1:0] w;
		w = DEG_EXT'(d);
		return w[DEGREE_BITS-1:0];
	endfunction

	// Present a stored degree on the 8-bit result field
	function automatic logic [7:0] deg_to_out(deg_t d);
		logic [DEG_EXT-1:0] w;
		w = DEG_EXT'(d);
		return w[7:0];
	endfunction

	function automatic ptr_t to_ptr(logic [3:0] i);
		logic [PTR_EXT-1:0] w;
		w = PTR_EXT'(i);
		return w[IDX_W-1:0];
	endfunction

endpackage

### rtl/core/sparse_polynomial_term_table.sv
// Sparse polynomial term table: SLOTS slots, each a signed Q16.16 coefficient and a
// degree, where a zero coefficient marks a free slot. One command per transaction:
// add (accumulate into the lowest live slot of equal degree, else fill the highest
// free slot, else drop with status 1), differentiate, read one slot, or clear. Sums
// and products saturate and report status 2. Every command returns one result.
// Commands run one at a time through a single-ported slot table walked by a
// pointer: add scans one slot per cycle, then selects and commits the slot;
// differentiate runs multiply then writeback per slot; read and clear go
// straight to loading the result register, which ends every command. The request
// side stalls while a command is in progress; a finished result waits in the
// output register without blocking the next request.
module sparse_polynomial_term_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  spt_pkg::spt_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output spt_pkg::spt_rsp_t rsp
);
	import spt_pkg::*;

	spt_ctl_t ctl;
	spt_sts_t sts;

	spt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_command (req.command),
		.req_stall   (req_stall),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.sts         (sts),
		.ctl         (ctl)
	);

	spt_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

### rtl/core/spt_ctrl.sv
module spt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic [1:0]          req_command,
	output logic                req_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	input  spt_pkg::spt_sts_t   sts,
	output spt_pkg::spt_ctl_t   ctl
);
	import spt_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.accept = 1'b1;
					unique case (req_command)
						CMD_ADD:  state_d = S_ADD_SCAN;
						CMD_DIFF: state_d = S_DIFF_MUL;
						default:  state_d = S_FINISH;
					endcase
				end
			end
			S_ADD_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.ptr_last) begin
					state_d = S_ADD_SEL;
				end
			end
			S_ADD_SEL: begin
				ctl.ptr_sel = 1'b1;
				state_d     = S_ADD_APPLY;
			end
			S_ADD_APPLY: begin
				ctl.apply = 1'b1;
				state_d   = S_FINISH;
			end
			S_DIFF_MUL: begin
				ctl.mul = 1'b1;
				state_d = S_DIFF_WR;
			end
			S_DIFF_WR: begin
				ctl.diff_wr = 1'b1;
				state_d     = sts.ptr_last ? S_FINISH : S_DIFF_MUL;
			end
			S_FINISH: begin
				if (!out_valid_q || !rsp_stall) begin
					ctl.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> !(out_valid_q && rsp_stall))
		else $error("result overwritten while stalled");

	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctl.finish))
		else $error("result valid without finish");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept |=> req_stall)
		else $error("accepted a transaction but not busy");

endmodule

### rtl/core/spt_dpath.sv
module spt_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  spt_pkg::spt_req_t   req,
	input  spt_pkg::spt_ctl_t   ctl,
	output spt_pkg::spt_sts_t   sts,
	output spt_pkg::spt_rsp_t   rsp
);
	import spt_pkg::*;

	logic signed [COEF_W-1:0] coef_arr_q [SLOTS];
	deg_t                     deg_arr_q  [SLOTS];

	logic [1:0]               cmd_q;
	logic signed [COEF_W-1:0] coef_q;
	deg_t                     deg_q;
	logic [3:0]               idx_q;
	ptr_t                     ptr_q;
	ptr_t                     hit_q;
	ptr_t                     free_q;
	logic                     hit_vld_q;
	logic                     free_vld_q;
	logic                     sat_q;
	logic                     full_q;

	logic signed [PROD_W-1:0] prod_s1;
	logic                     live_s1;
	logic                     degz_s1;
	deg_t                     deg_s1;

	spt_rsp_t                 rsp_q;

	logic signed [COEF_W-1:0] rd_coef;
	deg_t                     rd_deg;
	logic                     rd_live;
	logic                     wr_en;
	logic signed [COEF_W-1:0] wr_coef;
	deg_t                     wr_deg;
	logic                     wr_sat;
	logic                     wr_full;
	coef_sat_t                add_res;
	coef_sat_t                mul_res;
	logic                     in_range;

	// Single read port at the pointer
	assign rd_coef = coef_arr_q[ptr_q];
	assign rd_deg  = deg_arr_q[ptr_q];
	assign rd_live = (rd_coef != '0);

	assign add_res  = sat_add(rd_coef, coef_q);
	assign mul_res  = clamp_prod(prod_s1);
	assign in_range = (32'(idx_q) < SLOTS_W32);

	assign sts.ptr_last = (ptr_q == LAST_SLOT);

	// Write port at the pointer: add commit or derivative writeback
	always_comb begin
		wr_en   = 1'b0;
		wr_coef = rd_coef;
		wr_deg  = rd_deg;
		wr_sat  = 1'b0;
		wr_full = 1'b0;
		if (ctl.apply && coef_q != '0) begin
			if (hit_vld_q) begin
				wr_en   = 1'b1;
				wr_coef = add_res.val;
				wr_sat  = add_res.sat;
			end else if (free_vld_q) begin
				wr_en   = 1'b1;
				wr_coef = coef_q;
				wr_deg  = deg_q;
			end else begin
				wr_full = 1'b1;
			end
		end else if (ctl.diff_wr && live_s1) begin
			wr_en = 1'b1;
			if (degz_s1) begin
				wr_coef = '0;
			end else begin
				wr_coef = mul_res.val;
				wr_deg  = deg_s1 - 1'b1;
				wr_sat  = mul_res.sat;
			end
		end
	end

	// Term table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				coef_arr_q[i] <= '0;
				deg_arr_q[i]  <= '0;
			end
		end else if (ctl.finish && cmd_q == CMD_CLEAR) begin
			for (int i = 0; i < SLOTS; i++) begin
				coef_arr_q[i] <= '0;
				deg_arr_q[i]  <= '0;
			end
		end else if (wr_en) begin
			coef_arr_q[ptr_q] <= wr_coef;
			deg_arr_q[ptr_q]  <= wr_deg;
		end
	end

	// Transaction fields, pointer and scan results
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q      <= req.command;
			coef_q     <= req.coef_value;
			deg_q      <= to_deg(req.degree);
			idx_q      <= req.slot_index;
			ptr_q      <= (req.command == CMD_READ) ? to_ptr(req.slot_index) : '0;
			hit_vld_q  <= 1'b0;
			free_vld_q <= 1'b0;
			sat_q      <= 1'b0;
			full_q     <= 1'b0;
		end else begin
			if (ctl.scan) begin
				if (rd_live && rd_deg == deg_q && !hit_vld_q) begin
					hit_vld_q <= 1'b1;
					hit_q     <= ptr_q;
				end else if (!rd_live) begin
					free_vld_q <= 1'b1;
					free_q     <= ptr_q;
				end
			end
			if (ctl.scan || ctl.diff_wr) begin
				ptr_q <= ptr_q + 1'b1;
			end else if (ctl.ptr_sel) begin
				ptr_q <= hit_vld_q ? hit_q : free_q;
			end
			if (wr_sat) begin
				sat_q <= 1'b1;
			end
			if (wr_full) begin
				full_q <= 1'b1;
			end
		end
	end

	// Multiply stage of the derivative pass
	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_s1 <= PROD_W'(rd_coef) * $signed({1'b0, rd_deg});
			live_s1 <= rd_live;
			degz_s1 <= (rd_deg == '0);
			deg_s1  <= rd_deg;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			if (full_q) begin
				rsp_q.status <= STAT_FULL;
			end else if (sat_q) begin
				rsp_q.status <= STAT_SAT;
			end else begin
				rsp_q.status <= STAT_OK;
			end
			if (cmd_q == CMD_READ && in_range) begin
				rsp_q.read_coef   <= rd_coef;
				rsp_q.read_degree <= deg_to_out(rd_deg);
				rsp_q.read_live   <= rd_live;
			end else begin
				rsp_q.read_coef   <= '0;
				rsp_q.read_degree <= '0;
				rsp_q.read_live   <= 1'b0;
			end
		end
	end

	assign rsp = rsp_q;

	a_full_needs_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.apply && wr_full) |-> (!hit_vld_q && !free_vld_q))
		else $error("add dropped although a slot was available");

endmodule

### tb/sparse_polynomial_term_table_test.sv
module sparse_polynomial_term_table_test;
	import spt_pkg::*;

	localparam int RANDOM_COMMANDS = 1750;
	localparam int HOLD_START      = 400;
	localparam int HOLD_CYCLES     = 300;
	localparam int CALM_FIRST      = 1000;
	localparam int CALM_LAST       = 1250;
	localparam int STUCK_LIMIT     = 3000;
	localparam int DRAIN_CYCLES    = 60;

	// Tracks the slot table and the replies it owes, checks each reply in order
	class term_table_tracker;
		logic signed [COEF_W-1:0] coef_of [SLOTS];
		deg_t                     deg_of  [SLOTS];
		spt_rsp_t                 due_replies [$];
		int                       commands_taken;
		int                       errors;

		function new();
			wipe();
			commands_taken = 0;
			errors         = 0;
		endfunction

		function void wipe();
			foreach (coef_of[i]) begin
				coef_of[i] = '0;
				deg_of[i]  = '0;
			end
		endfunction

		function logic signed [COEF_W-1:0] clamp_coef(longint v, inout bit sat);
			if (v > longint'(COEF_MAX)) begin
				sat = 1'b1;
				return COEF_MAX;
			end
			if (v < longint'(COEF_MIN)) begin
				sat = 1'b1;
				return COEF_MIN;
			end
			return v[COEF_W-1:0];
		endfunction

		// Apply one accepted command to the table and queue the reply it owes
		function void log_command(spt_req_t r);
			spt_rsp_t want;
			bit       sat;
			int       hit;
			int       spare;
			deg_t     d;
			want  = '0;
			sat   = 1'b0;
			hit   = -1;
			spare = -1;
			d     = deg_t'(r.degree);
			commands_taken++;
			case (cmd_code_t'(r.command))
				CMD_ADD: begin
					if (r.coef_value != 0) begin
						// lowest live slot of equal degree, else highest free slot
						for (int i = 0; i < SLOTS; i++) begin
							if (coef_of[i] != 0 && deg_of[i] == d) begin
								if (hit < 0)
									hit = i;
							end else if (coef_of[i] == 0) begin
								spare = i;
							end
						end
						if (hit >= 0) begin
							coef_of[hit] = clamp_coef(longint'(coef_of[hit]) +
								longint'(r.coef_value), sat);
							if (sat)
								want.status = STAT_SAT;
						end else if (spare >= 0) begin
							coef_of[spare] = r.coef_value;
							deg_of[spare]  = d;
						end else begin
							want.status = STAT_FULL;
						end
					end
				end
				CMD_DIFF: begin
					// free slots keep their contents; constant terms vanish
					for (int i = 0; i < SLOTS; i++) begin
						if (coef_of[i] != 0) begin
							if (deg_of[i] != 0) begin
								coef_of[i] = clamp_coef(longint'(coef_of[i]) *
									longint'(deg_of[i]), sat);
								deg_of[i]  = deg_of[i] - 1'b1;
							end else begin
								coef_of[i] = '0;
							end
						end
					end
					if (sat)
						want.status = STAT_SAT;
				end
				CMD_READ: begin
					if (32'(r.slot_index) < SLOTS) begin
						want.read_coef   = coef_of[r.slot_index];
						want.read_degree = 8'(deg_of[r.slot_index]);
						want.read_live   = (coef_of[r.slot_index] != 0);
					end
				end
				default: wipe();
			endcase
			due_replies.push_back(want);
		endfunction

		function void report(string field, logic [31:0] want, logic [31:0] got);
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		endfunction

		// Compare one accepted reply with the oldest one owed
		function void check_reply(spt_rsp_t got);
			spt_rsp_t want;
			if (due_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected reply, expected none, actual %0h", $time, got);
				return;
			end
			want = due_replies.pop_front();
			if (got.status !== want.status)
				report("status", 32'(want.status), 32'(got.status));
			if (got.read_coef !== want.read_coef)
				report("read_coef", want.read_coef, got.read_coef);
			if (got.read_degree !== want.read_degree)
				report("read_degree", 32'(want.read_degree), 32'(got.read_degree));
			if (got.read_live !== want.read_live)
				report("read_live", 32'(want.read_live), 32'(got.read_live));
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	spt_req_t req;
	logic     rsp_valid;
	logic     rsp_stall;
	spt_rsp_t rsp;

	term_table_tracker book = new();

	sparse_polynomial_term_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Neither side idles while the command count is inside this window
	function automatic bit calm();
		return book.commands_taken >= CALM_FIRST && book.commands_taken < CALM_LAST;
	endfunction

	function automatic spt_req_t mk(cmd_code_t c, logic signed [31:0] v, logic [7:0] d,
			logic [3:0] s);
		spt_req_t r;
		r.command    = c;
		r.coef_value = v;
		r.degree     = d;
		r.slot_index = s;
		return r;
	endfunction

	function automatic logic signed [31:0] random_coef();
		int pick;
		logic signed [31:0] v;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			v = '0;
		end else if (pick < 16) begin
			case ($urandom_range(0, 3))
				0: v = COEF_MAX;
				1: v = COEF_MIN;
				2: v = 32'sd1;
				default: v = -32'sd1;
			endcase
		end else if (pick < 55) begin
			v = 32'($urandom_range(1, 8)) << 16;
			if ($urandom_range(0, 1))
				v = -v;
		end else begin
			v = $urandom;
		end
		return v;
	endfunction

	// Mostly adds over a narrow degree range so slots collide and the table fills
	function automatic spt_req_t random_command();
		spt_req_t r;
		int pick;
		pick         = $urandom_range(0, 99);
		r.coef_value = $urandom;
		r.degree     = 8'($urandom_range(0, 255));
		r.slot_index = 4'($urandom_range(0, 15));
		if (pick < 55) begin
			r.command    = CMD_ADD;
			r.coef_value = random_coef();
			if ($urandom_range(0, 99) < 75)
				r.degree = 8'($urandom_range(0, 19));
		end else if (pick < 83) begin
			r.command = CMD_READ;
		end else if (pick < 98) begin
			r.command = CMD_DIFF;
		end else begin
			r.command = CMD_CLEAR;
		end
		return r;
	endfunction

	// Offer one transaction from a falling edge; return at the falling edge after it is taken
	task automatic drive_item(spt_req_t item);
		while (!calm() && $urandom_range(0, 99) < 15) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		book.log_command(item);
		@(negedge clk);
	endtask

	task automatic directed_pass();
		drive_item(mk(CMD_READ, 32'sd0, 8'd0, 4'd0));
		// zero coefficient leaves the table alone
		drive_item(mk(CMD_ADD, 32'sd0, 8'd7, 4'd0));
		drive_item(mk(CMD_ADD, COEF_MAX, 8'd255, 4'd0));
		// matching degree, sum clamps high
		drive_item(mk(CMD_ADD, COEF_MAX, 8'd255, 4'd15));
		drive_item(mk(CMD_ADD, 32'sh0001_0000, 8'd3, 4'd0));
		// sum of zero frees the slot
		drive_item(mk(CMD_ADD, -32'sh0001_0000, 8'd3, 4'd0));
		drive_item(mk(CMD_ADD, 32'sh0002_0000, 8'd0, 4'd0));
		// product clamps, constant term vanishes
		drive_item(mk(CMD_DIFF, 32'shFFFF_FFFF, 8'hFF, 4'hF));
		// fill every remaining slot
		for (int i = 0; i < 15; i++) begin
			drive_item(mk(CMD_ADD, i[0] ? COEF_MIN : 32'(i + 1) << 16, 8'(i), 4'(i)));
		end
		// no slot left, add is dropped
		drive_item(mk(CMD_ADD, 32'sd7, 8'd200, 4'd0));
		// sum clamps low
		drive_item(mk(CMD_ADD, -32'sd1, 8'd1, 4'd0));
		drive_item(mk(CMD_CLEAR, 32'sd0, 8'd0, 4'd0));
	endtask

	// Request side: reset, directed commands, then random commands
	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		directed_pass();
		repeat (RANDOM_COMMANDS)
			drive_item(random_command());
		req_valid <= 1'b0;
		while (book.due_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.errors == 0)
			$display("sparse_polynomial_term_table_test: done, clean");
		else
			$display("sparse_polynomial_term_table_test: done, errors");
		$finish;
	end

	// Reply side: random stalls, one long hold-off to back the block up
	initial begin
		int  hold_left;
		bit  held;
		hold_left = 0;
		held      = 1'b0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && book.commands_taken >= HOLD_START) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (calm()) begin
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < 15);
			end
		end
	end

	// Check each reply transaction
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			book.check_reply(rsp);
	end

	// End the run if no transaction moves for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STUCK_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("sparse_polynomial_term_table_test: done, errors");
		$finish;
	end

endmodule
